>>> src/ktom_pkg.sv
// Constants for the keyword token opcode matcher: keyword text, opcodes and
// special byte codes. No dependencies.
package ktom_pkg;

    localparam int KW_COUNT = 12;
    localparam int KW_CHARS = 128;
    localparam int LEN_W    = 8;
    localparam int CODE_W   = 4;

    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam logic [7:0] CHAR_SEMI    = 8'h3B;

    localparam logic [CODE_W-1:0] CODE_UNKNOWN = 4'd0;
    localparam logic [KW_COUNT-1:0] ALL_LIVE   = {KW_COUNT{1'b1}};
    localparam logic [LEN_W-1:0] LEN_MAX       = {LEN_W{1'b1}};

    // Opcodes that a matched keyword reports.
    localparam logic [CODE_W-1:0] OP_SHOW       = 4'd1;
    localparam logic [CODE_W-1:0] OP_INC        = 4'd2;
    localparam logic [CODE_W-1:0] OP_LOOP_BEGIN = 4'd3;
    localparam logic [CODE_W-1:0] OP_LOOP_END   = 4'd4;
    localparam logic [CODE_W-1:0] OP_MOVE_LEFT  = 4'd5;
    localparam logic [CODE_W-1:0] OP_MOVE_RIGHT = 4'd6;
    localparam logic [CODE_W-1:0] OP_FUNC_BEGIN = 4'd7;
    localparam logic [CODE_W-1:0] OP_FUNC_END   = 4'd8;
    localparam logic [CODE_W-1:0] OP_SYSCALL    = 4'd9;
    localparam logic [CODE_W-1:0] OP_JUMP       = 4'd10;
    localparam logic [CODE_W-1:0] OP_DEC        = 4'd11;
    localparam logic [CODE_W-1:0] OP_ASK        = 4'd12;

    typedef logic [KW_CHARS*8-1:0] kw_text_t;

    // Literals are right-justified: the last character sits in the low byte.
    localparam kw_text_t KW_TEXT [KW_COUNT] = '{
        {"May_you_please_", "show_the_ASCII_value_of_the_current_cell"},
        {"May_you_please_", "increment_the_value_of_the_current_cell_by_one"},
        {"May_you_please_", "decrement_the_value_of_the_current_cell_by_one"},
        {"May_you_please_begin_a_loop_and_stop_it_only_if_the_value_stored_",
         "in_the_cell_where_it_started_is_zero"},
        {"May_you_please_end_the_current_loop_which_will_stop_only_if_the_",
         "value_stored_in_the_cell_where_it_started_is_zero"},
        {"May_you_please_move_the_pointer_by_one_position_to_what_the_",
         "original_developper_of_this_programming_language_calls_the_right"},
        {"May_you_please_move_the_pointer_by_one_position_to_what_the_",
         "original_developper_of_this_programming_language_calls_the_left"},
        {"May_you_please_", "begin_a_function"},
        {"May_you_please_", "end_the_current_function"},
        {"May_you_please_", "call_the_corresponding_syscall_of_the_current_cell"},
        {"May_you_please_", "jump_to_the_last_function_starting_from_here"},
        {"May_you_please_", "ask_the_guy_in_front_of_the_screen_for_a_value"}
    };

    localparam logic [CODE_W-1:0] KW_CODE [KW_COUNT] = '{
        OP_SHOW, OP_INC, OP_DEC, OP_LOOP_BEGIN, OP_LOOP_END, OP_MOVE_RIGHT,
        OP_MOVE_LEFT, OP_FUNC_BEGIN, OP_FUNC_END, OP_SYSCALL, OP_JUMP, OP_ASK
    };

    // Count the characters of a keyword; evaluated at elaboration only.
    function automatic int kw_len(input int k);
        int n;
        n = 0;
        for (int i = 0; i < KW_CHARS; i++) begin
            if (KW_TEXT[k][i*8 +: 8] != 8'h00) begin
                n = i + 1;
            end
        end
        return n;
    endfunction

endpackage

>>> src/keyword_token_opcode_matcher.sv
// Keyword token opcode matcher top level: input register, keyword lanes and
// result register. Depends on ktom_pkg.
//
// The block scans source bytes, one beat per cycle, and sustains one byte per
// clock with no bubbles while the result side takes its beats: a byte is
// registered at the input, then twelve keyword lanes compare it against their
// expected character at the current word position and, once the result slot
// is free, the result register captures any opcode. Space and
// newline are skipped. A ';' closes the word and produces one result beat:
// the opcode (1 to 12) of the keyword equal to the word, or opcode 0 with the
// unknown flag set. Every other byte, including control and high bytes,
// extends the word; words longer than any keyword simply fail to match, the
// length counter saturating at 255. Back-pressure on the result side stalls
// the pipeline in place; the input register keeps taking a byte while a
// result waits, as long as its own slot frees up.
module keyword_token_opcode_matcher (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] char_byte
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata    // [3:0] opcode, [4] unknown_word, [7:5] zero
);

    localparam int NK = ktom_pkg::KW_COUNT;
    localparam int LW = ktom_pkg::LEN_W;
    localparam int CW = ktom_pkg::CODE_W;

    // Input stage.
    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;

    // Word state.
    logic [NK-1:0] live_mask_reg, live_mask_next;
    logic [LW-1:0] word_len_reg, word_len_next;

    // Result stage.
    logic          out_valid_reg, out_valid_next;
    logic [CW-1:0] out_code_reg, out_code_next;
    logic          out_unknown_reg, out_unknown_next;

    logic          advance;
    logic          fire;
    logic          is_skip;
    logic          is_semi;
    logic [NK-1:0] keep;
    logic [NK-1:0] hit;
    logic [CW-1:0] match_code;

    // Result slot frees when empty or being taken this cycle.
    assign advance       = !out_valid_reg || m_axis_tready;
    assign fire          = in_valid_reg && advance;
    assign s_axis_tready = !in_valid_reg || advance;

    assign is_skip = (in_byte_reg == ktom_pkg::CHAR_SPACE) ||
                     (in_byte_reg == ktom_pkg::CHAR_NEWLINE);
    assign is_semi = (in_byte_reg == ktom_pkg::CHAR_SEMI);

    // One lane per keyword: expected character at the current position and
    // full-length test for the terminator.
    for (genvar k = 0; k < NK; k++) begin : g_lane
        localparam int KL = ktom_pkg::kw_len(k);
        localparam logic [LW-1:0] KL_W = LW'(KL);
        logic [7:0] exp_char;
        logic       in_range;

        assign in_range = (word_len_reg < KL_W);
        always_comb begin
            exp_char = 8'h00;
            if (in_range) begin
                exp_char = ktom_pkg::KW_TEXT[k][8*(KL - 1 - int'(word_len_reg)) +: 8];
            end
        end
        assign keep[k] = live_mask_reg[k] && in_range && (exp_char == in_byte_reg);
        assign hit[k]  = live_mask_reg[k] && (word_len_reg == KL_W);
    end

    // At most one lane can hit; scan in order so the last one wins.
    always_comb begin
        match_code = ktom_pkg::CODE_UNKNOWN;
        for (int k = 0; k < NK; k++) begin
            if (hit[k]) begin
                match_code = ktom_pkg::KW_CODE[k];
            end
        end
    end

    always_comb begin
        in_valid_next    = in_valid_reg;
        live_mask_next   = live_mask_reg;
        word_len_next    = word_len_reg;
        out_valid_next   = out_valid_reg;
        out_code_next    = out_code_reg;
        out_unknown_next = out_unknown_reg;

        // Drop the held byte once processed, then load a new one if offered.
        if (fire) begin
            in_valid_next = 1'b0;
        end
        if (s_axis_tvalid && s_axis_tready) begin
            in_valid_next = 1'b1;
        end

        if (advance) begin
            out_valid_next = 1'b0;
        end

        if (fire && !is_skip) begin
            if (is_semi) begin
                out_valid_next   = 1'b1;
                out_code_next    = match_code;
                out_unknown_next = (match_code == ktom_pkg::CODE_UNKNOWN);
                live_mask_next   = ktom_pkg::ALL_LIVE;
                word_len_next    = '0;
            end else begin
                live_mask_next = keep;
                if (word_len_reg != ktom_pkg::LEN_MAX) begin
                    word_len_next = word_len_reg + LW'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            live_mask_reg <= ktom_pkg::ALL_LIVE;
            word_len_reg  <= '0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            live_mask_reg <= live_mask_next;
            word_len_reg  <= word_len_next;
        end
    end

    // Payload registers: no reset.
    always_ff @(posedge aclk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            in_byte_reg <= s_axis_tdata;
        end
        out_code_reg    <= out_code_next;
        out_unknown_reg <= out_unknown_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'b000, out_unknown_reg, out_code_reg};

endmodule

>>> bench/tb_top.sv
// Self-checking bench for keyword_token_opcode_matcher: streams source bytes,
// predicts the opcode of every ';'-closed word and checks each result beat.
// Depends on ktom_pkg and the keyword_token_opcode_matcher RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 400_000;
    localparam int TAIL_CYCLES  = 8;
    localparam int PHASE_CHARS  = 60;
    localparam int PHASE_WORDS  = 4;
    localparam int SAT_LEN      = 260;

    typedef logic [7:0] text_q_t [$];

    typedef struct packed {
        logic [ktom_pkg::CODE_W-1:0] opcode;
        logic                        unknown_word;
    } verdict_t;

    logic       aclk          = 1'b0;
    logic       aresetn       = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata  = 8'h00;   // [7:0] char_byte
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;            // [3:0] opcode, [4] unknown_word, [7:5] zero

    // Keyword dictionary and the opcode each keyword reports.
    string                       kw_words   [ktom_pkg::KW_COUNT];
    logic [ktom_pkg::CODE_W-1:0] kw_opcodes [ktom_pkg::KW_COUNT];

    // Scanner state mirrored by the predictor.
    logic [ktom_pkg::KW_COUNT-1:0] live_kw;
    logic [ktom_pkg::LEN_W-1:0]    word_len;

    logic [7:0] chars_pending [$];   // bytes waiting to be driven
    verdict_t   verdicts_due  [$];   // opcodes predicted but not yet seen

    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int fail_count     = 0;
    int cycle_count    = 0;
    int word_chars     = 0;   // bytes sent that are not whitespace
    int words_closed   = 0;   // ';' bytes sent, one result each
    bit char_taken     = 1'b0;

    keyword_token_opcode_matcher u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Advance the scanner by one accepted byte; on ';' queue the opcode the
    // word should produce and clear the word.
    task automatic track_char(input logic [7:0] ch);
        verdict_t v;
        if (ch == ktom_pkg::CHAR_NEWLINE || ch == ktom_pkg::CHAR_SPACE) begin
            return;
        end
        if (ch == ktom_pkg::CHAR_SEMI) begin
            v.opcode = ktom_pkg::CODE_UNKNOWN;
            for (int k = 0; k < ktom_pkg::KW_COUNT; k++) begin
                if (live_kw[k] && kw_words[k].len() == int'(word_len)) begin
                    v.opcode = kw_opcodes[k];
                end
            end
            v.unknown_word = (v.opcode == ktom_pkg::CODE_UNKNOWN);
            verdicts_due.push_back(v);
            live_kw  = ktom_pkg::ALL_LIVE;
            word_len = '0;
        end else begin
            // Drop every keyword whose character at this position differs,
            // or that is already shorter than the word.
            for (int k = 0; k < ktom_pkg::KW_COUNT; k++) begin
                if (live_kw[k] && !(int'(word_len) < kw_words[k].len() &&
                                    kw_words[k][int'(word_len)] == ch)) begin
                    live_kw[k] = 1'b0;
                end
            end
            if (word_len != ktom_pkg::LEN_MAX) begin
                word_len++;
            end
        end
    endtask

    task automatic put_char(input logic [7:0] ch);
        chars_pending.push_back(ch);
        if (ch != ktom_pkg::CHAR_SPACE && ch != ktom_pkg::CHAR_NEWLINE) begin
            word_chars++;
        end
        if (ch == ktom_pkg::CHAR_SEMI) begin
            words_closed++;
        end
    endtask

    // Queue a word and its closing ';', scattering whitespace at gap_pct.
    task automatic send_word(input text_q_t w, input int gap_pct);
        foreach (w[i]) begin
            if ($urandom_range(99) < gap_pct) begin
                put_char($urandom_range(1) ? ktom_pkg::CHAR_SPACE : ktom_pkg::CHAR_NEWLINE);
            end
            put_char(w[i]);
        end
        put_char(ktom_pkg::CHAR_SEMI);
    endtask

    function automatic text_q_t keyword_text(input int k);
        text_q_t q;
        for (int i = 0; i < kw_words[k].len(); i++) begin
            q.push_back(kw_words[k][i]);
        end
        return q;
    endfunction

    // Hold until every queued byte is in and every predicted beat is out.
    task automatic drain();
        while (chars_pending.size() != 0 || verdicts_due.size() != 0 || s_axis_tvalid) begin
            @(negedge aclk);
        end
    endtask

    // One random phase: real keywords, damaged ones and noise words.
    task automatic run_phase(input int src_pct, input int sink_pct);
        int      first_chars;
        int      first_words;
        int      pick;
        int      k;
        int      cut;
        text_q_t w;
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
        first_chars    = word_chars;
        first_words    = words_closed;
        while (word_chars - first_chars < PHASE_CHARS ||
               words_closed - first_words < PHASE_WORDS) begin
            pick = $urandom_range(99);
            k    = $urandom_range(ktom_pkg::KW_COUNT - 1);
            w    = keyword_text(k);
            if (pick < 45) begin
                send_word(w, $urandom_range(1) ? 0 : 8);
            end else if (pick < 55) begin
                // corrupt one character
                cut    = $urandom_range(w.size() - 1);
                w[cut] = 8'($urandom_range(255));
                send_word(w, 0);
            end else if (pick < 63) begin
                // cut to a prefix, possibly empty
                cut = $urandom_range(w.size() - 1);
                while (w.size() > cut) begin
                    void'(w.pop_back());
                end
                send_word(w, 0);
            end else if (pick < 70) begin
                w.push_back(8'($urandom_range(255)));
                send_word(w, 0);
            end else begin
                // short noise word of any bytes; a stray ';' just splits it
                w.delete();
                repeat ($urandom_range(6)) begin
                    w.push_back(8'($urandom_range(255)));
                end
                send_word(w, 0);
            end
        end
        drain();
    endtask

    initial begin : stimulus
        string   head;
        text_q_t w;
        head = "May_you_please_";
        kw_words[0]  = {head, "show_the_ASCII_value_of_the_current_cell"};
        kw_words[1]  = {head, "increment_the_value_of_the_current_cell_by_one"};
        kw_words[2]  = {head, "decrement_the_value_of_the_current_cell_by_one"};
        kw_words[3]  = {head, "begin_a_loop_and_stop_it_only_if_the_value_stored_",
                        "in_the_cell_where_it_started_is_zero"};
        kw_words[4]  = {head, "end_the_current_loop_which_will_stop_only_if_the_",
                        "value_stored_in_the_cell_where_it_started_is_zero"};
        kw_words[5]  = {head, "move_the_pointer_by_one_position_to_what_the_",
                        "original_developper_of_this_programming_language_calls_the_right"};
        kw_words[6]  = {head, "move_the_pointer_by_one_position_to_what_the_",
                        "original_developper_of_this_programming_language_calls_the_left"};
        kw_words[7]  = {head, "begin_a_function"};
        kw_words[8]  = {head, "end_the_current_function"};
        kw_words[9]  = {head, "call_the_corresponding_syscall_of_the_current_cell"};
        kw_words[10] = {head, "jump_to_the_last_function_starting_from_here"};
        kw_words[11] = {head, "ask_the_guy_in_front_of_the_screen_for_a_value"};
        kw_opcodes = '{ktom_pkg::OP_SHOW, ktom_pkg::OP_INC, ktom_pkg::OP_DEC,
                       ktom_pkg::OP_LOOP_BEGIN, ktom_pkg::OP_LOOP_END,
                       ktom_pkg::OP_MOVE_RIGHT, ktom_pkg::OP_MOVE_LEFT,
                       ktom_pkg::OP_FUNC_BEGIN, ktom_pkg::OP_FUNC_END,
                       ktom_pkg::OP_SYSCALL, ktom_pkg::OP_JUMP, ktom_pkg::OP_ASK};

        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed words, no idling on either side.
        w.delete();
        send_word(w, 0);                       // empty word
        for (int k = 0; k < ktom_pkg::KW_COUNT; k++) begin
            send_word(keyword_text(k), 0);     // every opcode
        end
        send_word(keyword_text(7), 30);        // whitespace inside a keyword
        put_char(ktom_pkg::CHAR_SPACE);        // whitespace only, then ';'
        put_char(ktom_pkg::CHAR_NEWLINE);
        put_char(ktom_pkg::CHAR_SEMI);
        w = keyword_text(7);
        w.push_back("x");                      // one byte too many
        send_word(w, 0);
        w = keyword_text(8);
        void'(w.pop_back());                   // one byte short
        send_word(w, 0);
        w = keyword_text(7);
        w[w.size() - 1] = 8'hFF;               // high byte in place of the last
        send_word(w, 0);
        w = '{8'h00, 8'h09, 8'h0D, 8'h7F, 8'h80, 8'hFF};
        send_word(w, 0);                       // control and high bytes
        w = keyword_text(7);
        while (w.size() < SAT_LEN) begin
            w.push_back("z");                  // run the length into saturation
        end
        send_word(w, 0);
        send_word(keyword_text(7), 0);         // word must be clean again
        drain();

        run_phase(0, 0);
        run_phase(63, 0);
        run_phase(0, 63);
        run_phase(14, 14);

        // Let any stray beat surface before the verdict.
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // Predict on each accepted byte; reset the mirrored scanner with the DUT.
    always @(posedge aclk) begin
        if (!aresetn) begin
            live_kw    = ktom_pkg::ALL_LIVE;
            word_len   = '0;
            char_taken = 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            track_char(s_axis_tdata);
            char_taken = 1'b1;
        end
    end

    // Drive the next byte at the falling edge; hold a beat until it is taken.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else if (char_taken || !s_axis_tvalid) begin
            char_taken = 1'b0;
            if (chars_pending.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= chars_pending.pop_front();
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Stall the result side at random.
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // Compare every result beat with the oldest predicted opcode.
    always @(posedge aclk) begin : result_check
        verdict_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (verdicts_due.size() == 0) begin
                $error("result beat 0x%02h with no result pending", m_axis_tdata);
                fail_count++;
            end else begin
                want = verdicts_due.pop_front();
                if (m_axis_tdata[3:0] !== want.opcode) begin
                    $error("opcode: expected %0d, got %0d", want.opcode, m_axis_tdata[3:0]);
                    fail_count++;
                end
                if (m_axis_tdata[4] !== want.unknown_word) begin
                    $error("unknown_word: expected %0b, got %0b",
                           want.unknown_word, m_axis_tdata[4]);
                    fail_count++;
                end
                if (m_axis_tdata[7:5] !== 3'b000) begin
                    $error("pad: expected 0, got %0d", m_axis_tdata[7:5]);
                    fail_count++;
                end
            end
        end
    end

    // Bound the run so that a hung handshake still ends it.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

endmodule
